/* rtl/ndd_pkg.sv */
// ----------------------------------------------------------------------------
// ndd_pkg: shared types and constants
// Field codes, fixed-point widths and the divider request/response bundles.
// ----------------------------------------------------------------------------
package ndd_pkg;

    localparam int DATA_W = 32;
    localparam int FRAC_W = 16;
    localparam int NUM_W  = 49;   // (a - b) * 2^16, signed
    localparam int DEN_W  = 33;   // xi - xj, signed

    localparam logic       ACT_LOAD = 1'b0;
    localparam logic       ACT_EVAL = 1'b1;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_DUP = 2'd1;
    localparam logic [1:0] STATUS_SAT = 2'd2;

    typedef struct packed {
        logic                    start;
        logic signed [NUM_W-1:0] num;
        logic signed [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quo;
        logic                     ovf;
    } div_rsp_t;

endpackage

/* rtl/newton_divided_difference_interp_unit.sv */
// ----------------------------------------------------------------------------
// newton_divided_difference_interp_unit: Newton interpolation, Q16.16
// Loads node pairs and evaluates the Newton polynomial, rebuilding the
// divided-difference table when it is stale.
// ----------------------------------------------------------------------------
// A load transaction is written to the node memories when it is accepted, and
// the unit stays ready. An evaluate transaction holds the unit busy. With a
// fresh table it runs one Horner step per remaining node (memory read,
// subtract, 32x32 multiply, rescale, add). After any load or point_count
// write the table is rebuilt first: a duplicate scan, a copy and n*(n-1)/2
// divisions on the bit-serial divider. The result waits in an output register.
// ----------------------------------------------------------------------------
module newton_divided_difference_interp_unit #(
    parameter int MAX_POINTS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [4:0]         cfg_wr_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_action,
    input  logic [3:0]         s_point_index,
    input  logic signed [31:0] s_node_x,
    input  logic signed [31:0] s_node_y,
    input  logic signed [31:0] s_query_x,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [31:0] m_interp_value,
    output logic [1:0]         m_status
);
    import ndd_pkg::*;

    localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_DUP_RI   = 5'd1;
    localparam logic [4:0] S_DUP_LI   = 5'd2;
    localparam logic [4:0] S_DUP_RJ   = 5'd3;
    localparam logic [4:0] S_DUP_CMP  = 5'd4;
    localparam logic [4:0] S_COPY_R   = 5'd5;
    localparam logic [4:0] S_COPY_W   = 5'd6;
    localparam logic [4:0] S_DD_R1    = 5'd7;
    localparam logic [4:0] S_DD_R2    = 5'd8;
    localparam logic [4:0] S_DD_DIV   = 5'd9;
    localparam logic [4:0] S_DD_WAIT  = 5'd10;
    localparam logic [4:0] S_BLD_END  = 5'd11;
    localparam logic [4:0] S_EV_R0    = 5'd12;
    localparam logic [4:0] S_EV_L0    = 5'd13;
    localparam logic [4:0] S_EV_R     = 5'd14;
    localparam logic [4:0] S_EV_D     = 5'd15;
    localparam logic [4:0] S_EV_M     = 5'd16;
    localparam logic [4:0] S_EV_S     = 5'd17;
    localparam logic [4:0] S_EV_A     = 5'd18;
    localparam logic [4:0] S_OUT      = 5'd19;

    logic [DATA_W-1:0] x_mem [MAX_POINTS];
    logic [DATA_W-1:0] y_mem [MAX_POINTS];
    logic [DATA_W-1:0] c_mem [MAX_POINTS];

    logic [4:0]         state_reg;
    logic [4:0]         pc_reg;
    logic               fresh_reg;
    logic [1:0]         tstat_reg;
    logic               sat_reg;
    logic [IDX_W-1:0]   i_reg, j_reg, k_reg;
    logic signed [31:0] xi_reg, ca_reg, xa_reg, c_reg, d_reg, r_reg, q_reg;
    logic signed [63:0] p_reg;
    logic signed [47:0] prod_reg;
    logic [31:0]        x_rd_reg, y_rd_reg, c_rd_reg;
    logic signed [31:0] res_val_reg;
    logic [1:0]         res_stat_reg;
    logic               m_valid_reg;
    logic signed [31:0] m_val_reg;
    logic [1:0]         m_stat_reg;

    logic [IDX_W-1:0]   nm1;
    logic [IDX_W-1:0]   addr_x, addr_y, addr_c;
    logic               c_we;
    logic [IDX_W-1:0]   c_waddr;
    logic [31:0]        c_wdata;
    logic               load_we;
    logic [IDX_W-1:0]   load_addr;
    logic               s_acc;
    logic signed [32:0] ev_diff;
    logic signed [31:0] ev_d;
    logic signed [48:0] ev_sum;
    logic signed [31:0] ev_r;
    logic               ev_ovf;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    ndd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_ready        = (state_reg == S_IDLE);
    assign s_acc          = s_valid && s_ready;
    assign m_valid        = m_valid_reg;
    assign m_interp_value = m_val_reg;
    assign m_status       = m_stat_reg;

    // effective node count minus one, clamped to 0..MAX_POINTS-1
    always_comb begin
        if (pc_reg == 5'd0)
            nm1 = '0;
        else if (32'(pc_reg) > MAX_POINTS)
            nm1 = IDX_W'(MAX_POINTS - 1);
        else
            nm1 = IDX_W'(pc_reg - 5'd1);
    end

    assign load_addr = IDX_W'(s_point_index);
    assign load_we   = s_acc && (s_action == ACT_LOAD) && (32'(s_point_index) < MAX_POINTS);

    always_comb begin
        addr_x = i_reg;
        addr_y = i_reg;
        addr_c = i_reg;
        unique case (state_reg)
            S_DUP_RJ: addr_x = j_reg;
            S_DD_R2: begin
                addr_c = i_reg - 1'b1;
                addr_x = i_reg - j_reg;
            end
            S_EV_R0:  addr_c = nm1;
            S_EV_R: begin
                addr_c = k_reg;
                addr_x = k_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        c_we    = 1'b0;
        c_waddr = i_reg;
        c_wdata = y_rd_reg;
        if (state_reg == S_COPY_W) begin
            c_we = 1'b1;
        end else if (state_reg == S_DD_WAIT && div_rsp.done) begin
            c_we    = 1'b1;
            c_wdata = div_rsp.quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_we) begin
            x_mem[load_addr] <= s_node_x;
            y_mem[load_addr] <= s_node_y;
        end
        x_rd_reg <= x_mem[addr_x];
        y_rd_reg <= y_mem[addr_y];
    end

    always_ff @(posedge aclk) begin
        if (c_we)
            c_mem[c_waddr] <= c_wdata;
        c_rd_reg <= c_mem[addr_c];
    end

    always_comb begin
        div_req.start = (state_reg == S_DD_DIV);
        div_req.num   = {NUM_W'(33'(ca_reg) - 33'(signed'(c_rd_reg)))} <<< FRAC_W;
        div_req.den   = DEN_W'(33'(xa_reg) - 33'(signed'(x_rd_reg)));
    end

    // Horner datapath pieces
    always_comb begin
        ev_diff = 33'(q_reg) - 33'(signed'(x_rd_reg));
        if (ev_diff[32] != ev_diff[31])
            ev_d = ev_diff[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            ev_d = ev_diff[31:0];
        ev_sum = 49'(c_reg) + 49'(prod_reg);
        ev_ovf = (ev_sum > 49'sh0_7FFF_FFFF) || (ev_sum < -49'sh0_8000_0000);
        if (ev_sum > 49'sh0_7FFF_FFFF)
            ev_r = 32'sh7FFF_FFFF;
        else if (ev_sum < -49'sh0_8000_0000)
            ev_r = 32'sh8000_0000;
        else
            ev_r = ev_sum[31:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            pc_reg      <= 5'd4;
            fresh_reg   <= 1'b0;
            tstat_reg   <= STATUS_OK;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // S_OUT handles the output register itself
            if (m_valid_reg && m_ready && state_reg != S_OUT)
                m_valid_reg <= 1'b0;
            if (cfg_wr_en) begin
                pc_reg    <= cfg_wr_data;
                fresh_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (load_we)
                        fresh_reg <= 1'b0;
                    if (s_acc && s_action == ACT_EVAL) begin
                        q_reg <= s_query_x;
                        i_reg <= '0;
                        if (fresh_reg) begin
                            sat_reg <= (tstat_reg == STATUS_SAT);
                            if (tstat_reg == STATUS_DUP) begin
                                res_val_reg  <= '0;
                                res_stat_reg <= STATUS_DUP;
                                state_reg    <= S_OUT;
                            end else begin
                                state_reg <= S_EV_R0;
                            end
                        end else begin
                            sat_reg   <= 1'b0;
                            state_reg <= (nm1 == '0) ? S_COPY_R : S_DUP_RI;
                        end
                    end
                end
                S_DUP_RI: state_reg <= S_DUP_LI;
                S_DUP_LI: begin
                    xi_reg    <= x_rd_reg;
                    j_reg     <= i_reg + 1'b1;
                    state_reg <= S_DUP_RJ;
                end
                S_DUP_RJ: state_reg <= S_DUP_CMP;
                S_DUP_CMP: begin
                    if (x_rd_reg == xi_reg) begin
                        fresh_reg    <= 1'b1;
                        tstat_reg    <= STATUS_DUP;
                        res_val_reg  <= '0;
                        res_stat_reg <= STATUS_DUP;
                        state_reg    <= S_OUT;
                    end else if (j_reg == nm1) begin
                        if (i_reg == nm1 - 1'b1) begin
                            i_reg     <= '0;
                            state_reg <= S_COPY_R;
                        end else begin
                            i_reg     <= i_reg + 1'b1;
                            state_reg <= S_DUP_RI;
                        end
                    end else begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= S_DUP_RJ;
                    end
                end
                S_COPY_R: state_reg <= S_COPY_W;
                S_COPY_W: begin
                    if (i_reg == nm1) begin
                        if (nm1 == '0) begin
                            state_reg <= S_BLD_END;
                        end else begin
                            i_reg     <= nm1;
                            j_reg     <= IDX_W'(1);
                            state_reg <= S_DD_R1;
                        end
                    end else begin
                        i_reg     <= i_reg + 1'b1;
                        state_reg <= S_COPY_R;
                    end
                end
                S_DD_R1: state_reg <= S_DD_R2;
                S_DD_R2: begin
                    ca_reg    <= c_rd_reg;
                    xa_reg    <= x_rd_reg;
                    state_reg <= S_DD_DIV;
                end
                S_DD_DIV: state_reg <= S_DD_WAIT;
                S_DD_WAIT: begin
                    if (div_rsp.done) begin
                        if (div_rsp.ovf)
                            sat_reg <= 1'b1;
                        if (i_reg == j_reg) begin
                            if (j_reg == nm1) begin
                                state_reg <= S_BLD_END;
                            end else begin
                                j_reg     <= j_reg + 1'b1;
                                i_reg     <= nm1;
                                state_reg <= S_DD_R1;
                            end
                        end else begin
                            i_reg     <= i_reg - 1'b1;
                            state_reg <= S_DD_R1;
                        end
                    end
                end
                S_BLD_END: begin
                    fresh_reg <= 1'b1;
                    tstat_reg <= sat_reg ? STATUS_SAT : STATUS_OK;
                    state_reg <= S_EV_R0;
                end
                S_EV_R0: state_reg <= S_EV_L0;
                S_EV_L0: begin
                    r_reg <= c_rd_reg;
                    if (nm1 == '0) begin
                        res_val_reg  <= c_rd_reg;
                        res_stat_reg <= sat_reg ? STATUS_SAT : STATUS_OK;
                        state_reg    <= S_OUT;
                    end else begin
                        k_reg     <= nm1 - 1'b1;
                        state_reg <= S_EV_R;
                    end
                end
                S_EV_R: state_reg <= S_EV_D;
                S_EV_D: begin
                    d_reg <= ev_d;
                    c_reg <= c_rd_reg;
                    if (ev_diff[32] != ev_diff[31])
                        sat_reg <= 1'b1;
                    state_reg <= S_EV_M;
                end
                S_EV_M: begin
                    p_reg     <= d_reg * r_reg;
                    state_reg <= S_EV_S;
                end
                S_EV_S: begin
                    // divide by 2^16, truncating toward zero
                    prod_reg  <= p_reg[63:16] + 48'(p_reg[63] && (p_reg[15:0] != 16'd0));
                    state_reg <= S_EV_A;
                end
                S_EV_A: begin
                    r_reg <= ev_r;
                    if (ev_ovf)
                        sat_reg <= 1'b1;
                    if (k_reg == '0) begin
                        res_val_reg  <= ev_r;
                        res_stat_reg <= (sat_reg || ev_ovf) ? STATUS_SAT : STATUS_OK;
                        state_reg    <= S_OUT;
                    end else begin
                        k_reg     <= k_reg - 1'b1;
                        state_reg <= S_EV_R;
                    end
                end
                S_OUT: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_val_reg   <= res_val_reg;
                        m_stat_reg  <= res_stat_reg;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> state_reg == S_DD_WAIT)
        else $error("divider result outside of wait state");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_DUP |-> m_interp_value == 32'sd0)
        else $error("duplicate status with nonzero value");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DD_WAIT) |-> (i_reg >= j_reg) && (i_reg <= nm1) && (j_reg != '0))
        else $error("divided-difference indices out of range");
    assert property (@(posedge aclk) disable iff (!aresetn)
        tstat_reg != 2'd3)
        else $error("bad table status");

endmodule

/* rtl/ndd_div.sv */
// ----------------------------------------------------------------------------
// ndd_div: iterative signed divider
// Restoring division of magnitudes, one quotient bit per cycle, truncation
// toward zero, result saturated to 32 bits.
// ----------------------------------------------------------------------------
module ndd_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  ndd_pkg::div_req_t req,
    output ndd_pkg::div_rsp_t rsp
);
    import ndd_pkg::*;

    localparam int CNT_W = $clog2(NUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] dvd_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] dsr_reg;
    logic             neg_reg;

    logic [DEN_W:0]   rem_shift;
    logic             qbit;
    logic [NUM_W-1:0] num_abs;
    logic [DEN_W-1:0] den_abs;

    always_comb begin
        num_abs   = req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
        den_abs   = req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
        rem_shift = {rem_reg, dvd_reg[NUM_W-1]};
        qbit      = (rem_shift >= {1'b0, dsr_reg});
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                dvd_reg  <= num_abs;
                dsr_reg  <= den_abs;
                rem_reg  <= '0;
                neg_reg  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
            end else if (busy_reg) begin
                rem_reg <= qbit ? DEN_W'(rem_shift - {1'b0, dsr_reg})
                                : DEN_W'(rem_shift);
                dvd_reg <= {dvd_reg[NUM_W-2:0], qbit};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // dvd_reg holds the quotient magnitude once the last bit is in
    always_comb begin
        rsp.done = done_reg;
        rsp.ovf  = 1'b0;
        if (neg_reg) begin
            if (dvd_reg > NUM_W'(64'h8000_0000)) begin
                rsp.quo = 32'sh8000_0000;
                rsp.ovf = 1'b1;
            end else begin
                rsp.quo = DATA_W'(-dvd_reg);
            end
        end else begin
            if (dvd_reg > NUM_W'(64'h7FFF_FFFF)) begin
                rsp.quo = 32'sh7FFF_FFFF;
                rsp.ovf = 1'b1;
            end else begin
                rsp.quo = DATA_W'(dvd_reg);
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg < CNT_W'(NUM_W))
        else $error("divider step count out of range");

endmodule
